// ===== rtl/ipru_pkg.sv =====
`default_nettype none

package ipru_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_SCALE_DEF = 8;

  // field widths
  localparam int COLOR_W   = 8;
  localparam int RGB_W     = 3 * COLOR_W;
  localparam int SCALE_W   = 4;
  localparam int ROWW_W    = 11;
  localparam int PAD_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b1;

  // opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // control part of one expansion job
  typedef struct packed {
    logic             drop;
    logic             ends_row;
    logic [PAD_W-1:0] pad;
    logic             from_mem;
  } job_ctl_t;

  // bytes of zero padding to reach 4-byte alignment of width*factor*3
  function automatic logic [PAD_W-1:0] pad_count(input logic [1:0] w_lo,
                                                 input logic [1:0] f_lo);
    logic [5:0] prod;
    prod = 6'(w_lo) * 6'(f_lo) * 6'd3;
    return PAD_W'(~prod[1:0] + 2'd1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ipru_emit.sv =====
`default_nettype none

module ipru_emit #(
  parameter int MAX_SCALE = ipru_pkg::MAX_SCALE_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      load,
  input  wire ipru_pkg::job_ctl_t        load_ctl,
  input  wire logic [$clog2(MAX_SCALE + 1)-1:0] load_cnt,
  input  wire logic [ipru_pkg::RGB_W-1:0] load_rgb,
  input  wire logic [ipru_pkg::RGB_W-1:0] mem_rgb,
  output logic                           can_load,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output logic [ipru_pkg::COLOR_W-1:0]   out_red,
  output logic [ipru_pkg::COLOR_W-1:0]   out_green,
  output logic [ipru_pkg::COLOR_W-1:0]   out_blue,
  output logic                           row_end,
  output logic [ipru_pkg::PAD_W-1:0]     pad_bytes,
  output logic                           last,
  output logic                           status
);

  localparam int CNT_W = $clog2(MAX_SCALE + 1);

  logic                       job_valid;
  logic [CNT_W-1:0]           job_cnt;
  ipru_pkg::job_ctl_t         job_ctl;
  logic [ipru_pkg::RGB_W-1:0] job_rgb;

  logic                       out_ready;
  logic                       fire;
  logic                       final_copy;
  logic                       done;
  logic [ipru_pkg::RGB_W-1:0] cur_rgb;

  assign out_ready  = !result_valid || !result_stall;
  assign fire       = job_valid && out_ready;
  assign final_copy = (job_cnt == CNT_W'(1));
  assign done       = fire && final_copy;
  assign can_load   = !job_valid || done;
  assign cur_rgb    = job_ctl.drop ? '0 : (job_ctl.from_mem ? mem_rgb : job_rgb);

  // job register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (load) begin
      job_valid <= 1'b1;
    end else if (done) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_cnt <= load_cnt;
      job_ctl <= load_ctl;
      job_rgb <= load_rgb;
    end else if (fire) begin
      job_cnt <= job_cnt - CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_red   <= cur_rgb[2*ipru_pkg::COLOR_W +: ipru_pkg::COLOR_W];
      out_green <= cur_rgb[ipru_pkg::COLOR_W +: ipru_pkg::COLOR_W];
      out_blue  <= cur_rgb[0 +: ipru_pkg::COLOR_W];
      row_end   <= final_copy && job_ctl.ends_row;
      pad_bytes <= (final_copy && job_ctl.ends_row) ? job_ctl.pad : '0;
      last      <= final_copy;
      status    <= job_ctl.drop;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/integer_pixel_replication_upscaler.sv =====
`default_nettype none

// Nearest-neighbor integer upscaler for 24-bit RGB. Each pixel request is
// written to a line store and sent out scale_factor times, one copy per
// result. The last pixel of a row (column reaching row_width-1) starts a
// replay of scale_factor-1 more rows; each tick request sends all copies of
// the next stored pixel. A pixel request during a replay is dropped and gives
// one result with status 1. The copy that closes an output row carries the
// 4-byte alignment pad in pad_bytes. Rate: the result register issues one
// copy per cycle while result_stall does not hold it, so a pixel or tick
// request occupies the emitter for scale_factor copies (1 to MAX_SCALE, 8 at
// the default); a dropped pixel gives one copy and an idle tick none. The next
// request is taken in the same cycle as the last copy of the previous one.
// The line store needs no clearing after reset. Configuration writes are
// expected only while idle.
module integer_pixel_replication_upscaler #(
  parameter int MAX_WIDTH = ipru_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE = ipru_pkg::MAX_SCALE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [ipru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ipru_pkg::CFG_DATA_W-1:0] cfg_data,
  // pixel / tick requests
  input  wire logic                          pixel_valid,
  output logic                               pixel_stall,
  input  wire logic                          opcode,
  input  wire logic [ipru_pkg::COLOR_W-1:0]  red,
  input  wire logic [ipru_pkg::COLOR_W-1:0]  green,
  input  wire logic [ipru_pkg::COLOR_W-1:0]  blue,
  // result copies
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [ipru_pkg::COLOR_W-1:0]       out_red,
  output logic [ipru_pkg::COLOR_W-1:0]       out_green,
  output logic [ipru_pkg::COLOR_W-1:0]       out_blue,
  output logic                               row_end,
  output logic [ipru_pkg::PAD_W-1:0]         pad_bytes,
  output logic                               last,
  output logic                               status
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column bits
  localparam int WW    = $clog2(MAX_WIDTH + 1);                   // width bits
  localparam int FW    = $clog2(MAX_SCALE + 1);                   // factor bits
  localparam int RW    = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1; // replay bits

  // configuration registers
  logic [ipru_pkg::SCALE_W-1:0] scale_factor;
  logic [ipru_pkg::ROWW_W-1:0]  row_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= ipru_pkg::SCALE_W'(1);
      row_width    <= ipru_pkg::ROWW_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        ipru_pkg::REG_SCALE: scale_factor <= cfg_data[ipru_pkg::SCALE_W-1:0];
        ipru_pkg::REG_WIDTH: row_width    <= cfg_data[ipru_pkg::ROWW_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped factor and width
  logic [31:0]   f32;
  logic [31:0]   w32;
  logic [FW-1:0] f_eff;
  logic [WW-1:0] w_eff;
  logic [ipru_pkg::PAD_W-1:0] pad;

  always_comb begin
    if (scale_factor == '0) begin
      f32 = 32'd1;
    end else if (32'(scale_factor) > 32'(MAX_SCALE)) begin
      f32 = 32'(MAX_SCALE);
    end else begin
      f32 = 32'(scale_factor);
    end
    if (row_width == '0) begin
      w32 = 32'd1;
    end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end else begin
      w32 = 32'(row_width);
    end
  end

  assign f_eff = FW'(f32);
  assign w_eff = WW'(w32);
  assign pad   = ipru_pkg::pad_count(w32[1:0], f32[1:0]);

  // row position and replay state
  logic [CW-1:0] column;
  logic [RW-1:0] replays_left;
  logic          ends_row;
  logic          replaying;

  assign ends_row  = (WW'(column) + WW'(1)) >= w_eff;
  assign replaying = (replays_left != '0);

  logic accept;
  logic can_load;
  logic is_pixel;
  logic store_px;
  logic read_px;

  assign pixel_stall = !can_load;
  assign accept      = pixel_valid && !pixel_stall;
  assign is_pixel    = (opcode == ipru_pkg::OP_PIXEL);
  assign store_px    = accept && is_pixel && !replaying;
  assign read_px     = accept && !is_pixel && replaying;

  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      replays_left <= '0;
    end else if (store_px || read_px) begin
      if (ends_row) begin
        column       <= '0;
        replays_left <= store_px ? RW'(f32 - 32'd1) : replays_left - RW'(1);
      end else begin
        column <= column + CW'(1);
      end
    end
  end

  // line store, read data registered and held until the next tick read
  logic [ipru_pkg::RGB_W-1:0] line_store [MAX_WIDTH];
  logic [ipru_pkg::RGB_W-1:0] mem_rgb;
  logic [ipru_pkg::RGB_W-1:0] px_rgb;

  assign px_rgb = {red, green, blue};

  always_ff @(posedge clk) begin
    if (store_px) begin
      line_store[column] <= px_rgb;
    end
    if (read_px) begin
      mem_rgb <= line_store[column];
    end
  end

  // job handed to the emitter
  logic               load;
  ipru_pkg::job_ctl_t load_ctl;
  logic [FW-1:0]      load_cnt;

  assign load = store_px || read_px || (accept && is_pixel && replaying);

  always_comb begin
    load_ctl.drop     = is_pixel && replaying;
    // a dropped pixel never closes a row
    load_ctl.ends_row = ends_row && !load_ctl.drop;
    load_ctl.pad      = pad;
    load_ctl.from_mem = !is_pixel;
    load_cnt          = load_ctl.drop ? FW'(1) : f_eff;
  end

  ipru_emit #(
    .MAX_SCALE(MAX_SCALE)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .load_ctl     (load_ctl),
    .load_cnt     (load_cnt),
    .load_rgb     (px_rgb),
    .mem_rgb      (mem_rgb),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .row_end      (row_end),
    .pad_bytes    (pad_bytes),
    .last         (last),
    .status       (status)
  );

  // a dropped pixel gives a single closing result that ends no row
  a_drop_single : assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> last && !row_end && pad_bytes == '0)
    else $error("dropped pixel result malformed");

  // a row can only end on the final copy of a request
  a_row_end_last : assert property (@(posedge clk) disable iff (rst)
    result_valid && row_end |-> last)
    else $error("row end on a non-final copy");

  // a tick with no replay pending leaves the row state alone
  a_idle_tick : assert property (@(posedge clk) disable iff (rst)
    accept && !is_pixel && !replaying |=> !replaying && $stable(column))
    else $error("idle tick changed row state");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // package constants used here
  localparam int COLOR_W       = ipru_pkg::COLOR_W;
  localparam int RGB_W         = ipru_pkg::RGB_W;
  localparam int PAD_W         = ipru_pkg::PAD_W;
  localparam int SCALE_W       = ipru_pkg::SCALE_W;
  localparam int ROWW_W        = ipru_pkg::ROWW_W;
  localparam int CFG_IDX_W     = ipru_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = ipru_pkg::CFG_DATA_W;
  localparam int MAX_WIDTH_DEF = ipru_pkg::MAX_WIDTH_DEF;
  localparam int MAX_SCALE_DEF = ipru_pkg::MAX_SCALE_DEF;
  localparam logic OP_PIXEL    = ipru_pkg::OP_PIXEL;
  localparam logic OP_TICK     = ipru_pkg::OP_TICK;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = ipru_pkg::REG_SCALE;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = ipru_pkg::REG_WIDTH;

  // run limits
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;   // extra wait after the last expected copy has been taken
  localparam int HOLD_CYCLES  = 400;  // long receiver hold-off for the back-pressure phase
  localparam int RANDOM_ITEMS = 60;

  // one emitted copy, in port order
  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
    logic               row_end;
    logic [PAD_W-1:0]   pad;
    logic               last;
    logic               status;
  } copy_t;

  // the single result of a pixel request that arrives while a replay is running
  localparam copy_t DROPPED = '{8'h00, 8'h00, 8'h00, 1'b0, 2'd0, 1'b1, 1'b1};

  // directed plan: register writes, and requests repeated reps times
  typedef enum logic {STEP_CFG, STEP_REQ} step_kind_t;
  typedef struct {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic                 op;
    logic [RGB_W-1:0]     rgb;
    int                   reps;
    bit                   typed;
    copy_t                want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic               pixel_valid = 1'b0;
  logic               pixel_stall;
  logic               opcode = OP_PIXEL;
  logic [COLOR_W-1:0] red = '0;
  logic [COLOR_W-1:0] green = '0;
  logic [COLOR_W-1:0] blue = '0;

  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [COLOR_W-1:0] out_red;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_blue;
  logic               row_end;
  logic [PAD_W-1:0]   pad_bytes;
  logic               last;
  logic               status;

  integer_pixel_replication_upscaler dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .opcode       (opcode),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .row_end      (row_end),
    .pad_bytes    (pad_bytes),
    .last         (last),
    .status       (status)
  );

  always #5 clk = ~clk;

  // shadow of the upscaler: line store, row position, replay count, registers
  logic [RGB_W-1:0] row_mem [0:MAX_WIDTH_DEF-1];
  int               col_pos;
  int               rows_to_replay;
  logic [SCALE_W-1:0] cur_scale;
  logic [ROWW_W-1:0]  cur_width;

  copy_t     copies_due[$];  // copies still to come, oldest first
  plan_row_t plan[$];
  int        errors = 0;
  bit        idling = 1'b1;  // random gaps on both sides
  bit        hold_request = 1'b0;

  // clamped factor and width, as the block uses them
  function automatic int eff_scale();
    if (cur_scale == 0) return 1;
    if (cur_scale > MAX_SCALE_DEF) return MAX_SCALE_DEF;
    return int'(cur_scale);
  endfunction

  function automatic int eff_width();
    if (cur_width == 0) return 1;
    if (cur_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(cur_width);
  endfunction

  // advance the shadow by one accepted request and queue the copies it causes;
  // a typed row replaces the predicted copies by the single one written in the plan
  function automatic int replicate(logic op, logic [RGB_W-1:0] rgb, bit typed, copy_t want);
    int               f;
    int               w;
    int               k;
    logic [PAD_W-1:0] pad;
    bit               closes;
    logic [RGB_W-1:0] px;
    copy_t            c;
    f = eff_scale();
    w = eff_width();
    pad = PAD_W'((4 - (w * f * 3) % 4) % 4);
    closes = (col_pos >= w - 1);
    if (op == OP_PIXEL) begin
      if (rows_to_replay != 0) begin
        copies_due.push_back(typed ? want : DROPPED);
        return 1;
      end
      row_mem[col_pos] = rgb;
      px = rgb;
    end else begin
      // tick with no replay running is swallowed
      if (rows_to_replay == 0) return 0;
      px = row_mem[col_pos];
    end
    if (typed) begin
      copies_due.push_back(want);
    end else begin
      for (k = 0; k < f; k++) begin
        c.r = px[23:16];
        c.g = px[15:8];
        c.b = px[7:0];
        c.last = (k == f - 1);
        c.row_end = c.last && closes;
        c.pad = c.row_end ? pad : '0;
        c.status = 1'b0;
        copies_due.push_back(c);
      end
    end
    if (closes) begin
      col_pos = 0;
      rows_to_replay = (op == OP_PIXEL) ? f - 1 : rows_to_replay - 1;
    end else begin
      col_pos++;
    end
    return f;
  endfunction

  function automatic void cfg_step(logic [CFG_IDX_W-1:0] idx, int value);
    plan_row_t s;
    s.kind = STEP_CFG;
    s.idx = idx;
    s.data = CFG_DATA_W'(value);
    s.op = OP_PIXEL;
    s.rgb = '0;
    s.reps = 0;
    s.typed = 1'b0;
    s.want = '0;
    plan.push_back(s);
  endfunction

  function automatic void req_step(logic op, logic [RGB_W-1:0] rgb, int reps, bit typed,
                                   copy_t want);
    plan_row_t s;
    s.kind = STEP_REQ;
    s.idx = '0;
    s.data = '0;
    s.op = op;
    s.rgb = rgb;
    s.reps = reps;
    s.typed = typed;
    s.want = want;
    plan.push_back(s);
  endfunction

  // register write, then cfg_we low again so back-to-back writes never share a step
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SCALE) cur_scale = SCALE_W'(value);
    else cur_width = ROWW_W'(value);
    @(posedge clk);
  endtask

  // offer one request, optionally after a gap, and predict once it is taken
  task automatic send_request(logic op, logic [RGB_W-1:0] rgb, bit typed, copy_t want,
                              output int n);
    if (idling && $urandom_range(0, 3) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    opcode <= op;
    red <= rgb[23:16];
    green <= rgb[15:8];
    blue <= rgb[7:0];
    do @(posedge clk); while (pixel_stall);
    n = replicate(op, rgb, typed, want);
  endtask

  function automatic logic [RGB_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return RGB_W'($urandom);
    endcase
  endfunction

  // mostly the request that keeps the row going, now and then a stray one
  task automatic random_request(output int n);
    logic op;
    if (rows_to_replay != 0) op = ($urandom_range(0, 9) == 0) ? OP_PIXEL : OP_TICK;
    else op = ($urandom_range(0, 9) == 0) ? OP_TICK : OP_PIXEL;
    send_request(op, pick_color(), 1'b0, '0, n);
  endtask

  // bring the block back to the start of a row with no replay pending
  task automatic finish_rows(inout int counted);
    int n;
    while (col_pos != 0 || rows_to_replay != 0) begin
      send_request(rows_to_replay != 0 ? OP_TICK : OP_PIXEL, pick_color(), 1'b0, '0, n);
      counted += (n > 0);
    end
  endtask

  // stop offering, wait for every expected copy, then let the emitter settle
  task automatic drain();
    pixel_valid <= 1'b0;
    while (copies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic note_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: random stall bursts, free runs, and the long hold when asked
  int stall_left = 0;
  int free_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      result_stall <= 1'b0;
    end else if (idling && $urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      result_stall <= 1'b1;
    end else begin
      free_left = $urandom_range(0, 20);
      result_stall <= 1'b0;
    end
  end

  // result checker: every accepted copy against the oldest expectation
  always @(posedge clk) begin : check_copy
    copy_t exp_c;
    if (!rst && result_valid && !result_stall) begin
      if (copies_due.size() == 0) begin
        $display("%0t: unexpected copy, expected none, actual %0h %0h %0h end=%0b pad=%0d",
                 $time, out_red, out_green, out_blue, row_end, pad_bytes);
        errors++;
      end else begin
        exp_c = copies_due.pop_front();
        note_field("out_red", exp_c.r, out_red);
        note_field("out_green", exp_c.g, out_green);
        note_field("out_blue", exp_c.b, out_blue);
        note_field("row_end", exp_c.row_end, row_end);
        note_field("pad_bytes", exp_c.pad, pad_bytes);
        note_field("last", exp_c.last, last);
        note_field("status", exp_c.status, status);
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    int r;
    int counted;
    col_pos = 0;
    rows_to_replay = 0;
    cur_scale = 1;
    cur_width = 1;

    // after reset: factor 1, width 1, every pixel closes a row with pad 1
    req_step(OP_PIXEL, 24'hFF00FF, 1, 1'b1, '{8'hFF, 8'h00, 8'hFF, 1'b1, 2'd1, 1'b1, 1'b0});
    // tick with nothing to replay: no copy
    req_step(OP_TICK, 24'h000000, 1, 1'b0, '0);
    req_step(OP_PIXEL, 24'h000000, 1, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1, 2'd1, 1'b1, 1'b0});
    // factor zero behaves as one
    cfg_step(REG_SCALE, 0);
    req_step(OP_PIXEL, 24'h123456, 1, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b1, 2'd1, 1'b1, 1'b0});
    // factor above the maximum clamps to 8, width zero behaves as one
    cfg_step(REG_SCALE, 15);
    cfg_step(REG_WIDTH, 0);
    req_step(OP_PIXEL, 24'hFFFFFF, 1, 1'b0, '0);
    // pixel during the replay is dropped and flagged
    req_step(OP_PIXEL, 24'h55AA55, 1, 1'b1, DROPPED);
    req_step(OP_TICK, 24'h000000, 7, 1'b0, '0);
    // three-wide row doubled, pad 2
    cfg_step(REG_SCALE, 2);
    cfg_step(REG_WIDTH, 3);
    req_step(OP_PIXEL, 24'h010203, 3, 1'b0, '0);
    req_step(OP_TICK, 24'h000000, 3, 1'b0, '0);
    // width shrunk mid-row: the next pixel closes the row at once
    cfg_step(REG_WIDTH, 4);
    req_step(OP_PIXEL, 24'h804020, 3, 1'b0, '0);
    cfg_step(REG_WIDTH, 2);
    req_step(OP_PIXEL, 24'hFE7F01, 1, 1'b0, '0);
    req_step(OP_TICK, 24'h000000, 2, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        for (r = 0; r < plan[i].reps; r++)
          send_request(plan[i].op, plan[i].rgb + RGB_W'(r * 24'h010203), plan[i].typed,
                       plan[i].want, n);
      end
    end
    counted = 0;
    finish_rows(counted);
    drain();

    // width register at its top value: no row ends early, then the row is cut short
    write_reg(REG_SCALE, 1);
    write_reg(REG_WIDTH, 2047);
    repeat (12) send_request(OP_PIXEL, pick_color(), 1'b0, '0, n);
    drain();
    write_reg(REG_WIDTH, 5);
    finish_rows(counted);
    drain();

    // back-pressure: result side holds off while requests keep coming
    idling = 1'b0;
    write_reg(REG_SCALE, 8);
    write_reg(REG_WIDTH, 3);
    hold_request = 1'b1;
    repeat (30) random_request(n);
    finish_rows(counted);
    drain();
    idling = 1'b1;

    // random settings, each phase a few rows ending clean
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      // last stretch runs with no gaps on either side
      if (counted > RANDOM_ITEMS - 20) idling = 1'b0;
      write_reg(REG_SCALE, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 8));
      case ($urandom_range(0, 9))
        0: write_reg(REG_WIDTH, 0);
        1: write_reg(REG_WIDTH, $urandom_range(7, 16));
        default: write_reg(REG_WIDTH, $urandom_range(1, 6));
      endcase
      repeat ($urandom_range(4, 24)) begin
        random_request(n);
        counted += (n > 0);
      end
      finish_rows(counted);
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
